// ===== hw/rtl/ilbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ilbs_pkg
// Shared types and constants for the input loss buffer sizer.
// ----------------------------------------------------------------------------
package ilbs_pkg;

    // Width of the max_loss register and of the per-gap push count
    localparam int unsigned LOSS_W     = 5;
    // Width of the frame number
    localparam int unsigned FRAME_W    = 32;
    // Width of the reported buffer size
    localparam int unsigned SIZE_W     = 4;
    // A bin counts as repeated at this many hits
    localparam int unsigned REPEAT_MIN = 2;
    // Reset value of max_loss
    localparam logic [LOSS_W-1:0] MAX_LOSS_RST = 5'd16;
    // Register index of max_loss
    localparam logic REG_MAX_LOSS = 1'b0;

    // Operation on the histogram register file
    typedef enum logic [1:0] {
        BIN_NOP,
        BIN_INC,
        BIN_DEC
    } t_bin_op;

endpackage

// ===== hw/rtl/ilbs_ram.sv =====
// ----------------------------------------------------------------------------
// ilbs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilbs_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ilbs_bins.sv =====
// ----------------------------------------------------------------------------
// ilbs_bins
// Histogram register file with one read-modify-write port per cycle and a
// shared repeat compare on the addressed bin.
// ----------------------------------------------------------------------------
module ilbs_bins
    import ilbs_pkg::*;
#(
    parameter int unsigned NUM_BINS = 16,
    parameter int unsigned CNT_W    = 7,
    parameter int unsigned IDX_W    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bin_op          i_op,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_repeat
);

    logic [CNT_W-1:0] r_bins [NUM_BINS];
    logic [CNT_W-1:0] rd_count;
    logic             idx_ok;

    // Addressed bin, zero outside the file
    assign idx_ok   = 32'(i_idx) < NUM_BINS;
    assign rd_count = idx_ok ? r_bins[i_idx] : '0;
    assign o_repeat = 32'(rd_count) >= REPEAT_MIN;

    // Increment or decrement one bin; a decrement never goes below zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
        end else if (idx_ok) begin
            case (i_op)
                BIN_INC: begin
                    r_bins[i_idx] <= rd_count + CNT_W'(1);
                end
                BIN_DEC: begin
                    if (rd_count != '0) begin
                        r_bins[i_idx] <= rd_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/input_loss_buffer_sizer.sv =====
// ----------------------------------------------------------------------------
// input_loss_buffer_sizer
// Tracks frame number gaps, keeps a ring window of loss values with an
// incremental histogram and reports the largest repeated loss value.
// ----------------------------------------------------------------------------
// Sequence: S_IDLE accepts a frame and S_CALC forms the gap. On an advancing frame,
// each pushed loss value takes S_RD, S_OLD (only while the window is full) and S_INC,
// then S_SCAN checks at most NUM_BINS bins top-down; S_DONE loads the output register.
// One transaction at a time; S_DONE waits on output stalls. Bins port and window RAM shared.
// Reset: synchronous active low; clears control state, histogram and
// max_loss (to 16). The window RAM is not cleared.
// ----------------------------------------------------------------------------
module input_loss_buffer_sizer
    import ilbs_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH  = 64,
    parameter int unsigned MAX_LOSS_BINS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] frame
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] buffer_size, [7:4] zero
    output logic [0:0]  m_axis_tuser,   // [0] updated
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Only values below 31 can ever be pushed, so higher bins stay empty
    localparam int unsigned NUM_BINS = (MAX_LOSS_BINS < 31) ? MAX_LOSS_BINS : 31;
    localparam int unsigned IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned POS_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CNT_W    = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_RD,
        S_OLD,
        S_INC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic                r_have, n_have;
    logic [FRAME_W-1:0]  r_last, n_last;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [POS_W-1:0]    r_wpos, n_wpos;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]    r_size, n_size;
    logic [IDX_W-1:0]    r_val, n_val;
    logic [IDX_W-1:0]    r_scan, n_scan;
    logic [LOSS_W-1:0]   r_cnt, n_cnt;
    logic                r_upd, n_upd;
    logic                r_m_valid, n_m_valid;
    logic [SIZE_W-1:0]   r_m_size, n_m_size;
    logic                r_m_upd, n_m_upd;
    logic [LOSS_W-1:0]   r_max_loss;

    logic [FRAME_W-1:0]  delta;
    logic                delta_pos;
    logic [LOSS_W-1:0]   cap_lim;
    logic [LOSS_W-1:0]   cap;
    logic                full;
    logic [POS_W-1:0]    wpos_inc;
    logic [7:0]          size_ext;

    t_bin_op             bin_op;
    logic [IDX_W-1:0]    bin_idx;
    logic                bin_repeat;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_rdata;

    logic                cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_MAX_LOSS) ? 32'(r_max_loss) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_loss <= MAX_LOSS_RST;
        end else if (cfg_wr && paddr[2] == REG_MAX_LOSS) begin
            r_max_loss <= pwdata[LOSS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Gap and push count
    // ------------------------------------------------------------------
    assign delta     = r_frame - r_last;
    assign delta_pos = (delta != '0) && !delta[FRAME_W-1];
    assign cap_lim   = (32'(r_max_loss) > NUM_BINS) ? LOSS_W'(NUM_BINS) : r_max_loss;
    assign cap       = ((delta[FRAME_W-1:LOSS_W] == '0) && (delta[LOSS_W-1:0] < cap_lim))
                       ? delta[LOSS_W-1:0] : cap_lim;

    assign full     = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign wpos_inc = (r_wpos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + POS_W'(1);

    // ------------------------------------------------------------------
    // Shared histogram port
    // ------------------------------------------------------------------
    always_comb begin
        bin_op  = BIN_NOP;
        bin_idx = r_scan;
        case (r_state)
            S_OLD: begin
                bin_op  = BIN_DEC;
                bin_idx = ram_rdata;
            end
            S_INC: begin
                bin_op  = BIN_INC;
                bin_idx = r_val;
            end
            default: begin
            end
        endcase
    end

    ilbs_bins #(
        .NUM_BINS (NUM_BINS),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_bins (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (bin_op),
        .i_idx    (bin_idx),
        .o_repeat (bin_repeat)
    );

    // ------------------------------------------------------------------
    // Ring window
    // ------------------------------------------------------------------
    assign ram_re = (r_state == S_RD) && full;
    assign ram_we = (r_state == S_INC);

    ilbs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (r_val),
        .i_re    (ram_re),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign size_ext = 8'(r_size);

    always_comb begin
        n_state   = r_state;
        n_have    = r_have;
        n_last    = r_last;
        n_frame   = r_frame;
        n_wpos    = r_wpos;
        n_fill    = r_fill;
        n_size    = r_size;
        n_val     = r_val;
        n_scan    = r_scan;
        n_cnt     = r_cnt;
        n_upd     = r_upd;
        n_m_valid = r_m_valid;
        n_m_size  = r_m_size;
        n_m_upd   = r_m_upd;

        // Output register drains independently
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_frame = s_axis_tdata;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_last = r_frame;
                n_upd  = 1'b0;
                n_val  = '0;
                n_scan = IDX_W'(NUM_BINS - 1);
                n_cnt  = cap;
                if (!r_have) begin
                    n_have  = 1'b1;
                    n_state = S_DONE;
                end else if (delta_pos) begin
                    n_upd   = 1'b1;
                    n_state = (cap == '0) ? S_SCAN : S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                // Full window: fetch the entry about to be overwritten
                if (full) begin
                    n_state = S_OLD;
                end else begin
                    n_fill  = r_fill + FILL_W'(1);
                    n_state = S_INC;
                end
            end
            S_OLD: begin
                n_state = S_INC;
            end
            S_INC: begin
                n_wpos  = wpos_inc;
                n_val   = r_val + IDX_W'(1);
                n_cnt   = r_cnt - LOSS_W'(1);
                n_state = (r_cnt == LOSS_W'(1)) ? S_SCAN : S_RD;
            end
            S_SCAN: begin
                // Top-down search for the first repeated bin
                if (bin_repeat) begin
                    n_size  = r_scan;
                    n_state = S_DONE;
                end else if (r_scan == '0) begin
                    n_size  = '0;
                    n_state = S_DONE;
                end else begin
                    n_scan = r_scan - IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_size  = size_ext[SIZE_W-1:0];
                    n_m_upd   = r_upd;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished scan reports the fresh size in the same transaction
        if (r_state == S_DONE && r_upd) begin
            n_m_size = (!r_m_valid || m_axis_tready) ? size_ext[SIZE_W-1:0] : r_m_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_have    <= 1'b0;
            r_last    <= '0;
            r_wpos    <= '0;
            r_fill    <= '0;
            r_size    <= '0;
            r_upd     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_have    <= n_have;
            r_last    <= n_last;
            r_wpos    <= n_wpos;
            r_fill    <= n_fill;
            r_size    <= n_size;
            r_upd     <= n_upd;
            r_m_valid <= n_m_valid;
        end
        r_frame  <= n_frame;
        r_val    <= n_val;
        r_scan   <= n_scan;
        r_cnt    <= n_cnt;
        r_m_size <= n_m_size;
        r_m_upd  <= n_m_upd;
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {4'd0, r_m_size};
    assign m_axis_tuser[0] = r_m_upd;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= WINDOW_DEPTH)
        else $error("fill count beyond window depth");

    a_wpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wpos) < WINDOW_DEPTH)
        else $error("write position outside window");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CALC))
        else $error("accepted transaction not processed");

    a_scan_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_INC) |-> r_upd)
        else $error("histogram work without an advancing frame");

    a_old_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD) |-> full)
        else $error("eviction from a window that is not full");

endmodule
